[hdl/strict_predecessor_successor_search_macros.svh]
// Assertion macros for the predecessor/successor search block.
// Used by files that carry concurrent assertions; no dependencies.
`ifndef STRICT_PREDECESSOR_SUCCESSOR_SEARCH_MACROS_SVH
`define STRICT_PREDECESSOR_SUCCESSOR_SEARCH_MACROS_SVH
// implication checked on every clock edge outside reset
`define SPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define SPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hdl/sps_pkg.sv]
// Package for the predecessor/successor search block: commands, codes, widths.
// No dependencies.
package sps_pkg;
	localparam int unsigned VALUE_W = 31;
	localparam int unsigned CMD_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef logic [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   below_found;
		value_t below_value;
		logic   above_found;
		value_t above_value;
	} result_t;
endpackage

[hdl/sps_scan.sv]
// Scan unit: compares memory read data against a query and folds the best
// strict predecessor and successor. Depends on sps_pkg.
module sps_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sps_pkg::value_t   key,
	input  logic              rd_valid,
	input  sps_pkg::value_t   rd_data,
	output sps_pkg::result_t  acc
);
	sps_pkg::value_t  key_q;
	logic             below_found_q;
	logic             above_found_q;
	sps_pkg::value_t  below_value_q;
	sps_pkg::value_t  above_value_q;
	logic             take_below;
	logic             take_above;

	assign take_below = rd_valid && (rd_data < key_q) &&
		(!below_found_q || rd_data > below_value_q);
	assign take_above = rd_valid && (rd_data > key_q) &&
		(!above_found_q || rd_data < above_value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			below_found_q <= 1'b0;
			above_found_q <= 1'b0;
		end else if (start) begin
			below_found_q <= 1'b0;
			above_found_q <= 1'b0;
		end else begin
			if (take_below)
				below_found_q <= 1'b1;
			if (take_above)
				above_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			below_value_q <= '0;
			above_value_q <= '0;
		end else begin
			if (take_below)
				below_value_q <= rd_data;
			if (take_above)
				above_value_q <= rd_data;
		end
	end

	assign acc.below_found = below_found_q;
	assign acc.below_value = below_value_q;
	assign acc.above_found = above_found_q;
	assign acc.above_value = above_value_q;
endmodule

[hdl/strict_predecessor_successor_search.sv]
// A query over N stored entries reads them from the table memory's one read
// port, one entry per cycle, and folds each into the scan unit. The result
// waits in an output register; clear and insert beats are taken while it
// waits, a query beat is held off until it leaves.
// Reset empties the table at once (entry count to zero); no clearing pass.
module strict_predecessor_successor_search #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // value[30:0], zero[31]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // below_value[30:0], above_value[61:31], zero[63:62]
	output logic [1:0]  m_tuser   // below_found[0], above_found[1]
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic          rd_valid_s1;
	sps_pkg::value_t mem [TABLE_DEPTH];
	sps_pkg::value_t rd_data_s1;
	sps_pkg::result_t acc;
	logic          out_valid_q;
	sps_pkg::result_t out_q;

	sps_pkg::cmd_t   cmd;
	sps_pkg::value_t val;
	logic            acc_beat;
	logic            scan_start;
	logic            rd_en;

	assign cmd = sps_pkg::cmd_t'(s_tuser);
	assign val = s_tdata[30:0];
	assign s_tready = (state_q == ST_IDLE) && !(cmd == sps_pkg::CMD_QUERY && out_valid_q);
	assign acc_beat = s_tvalid && s_tready;
	assign scan_start = acc_beat && cmd == sps_pkg::CMD_QUERY;
	assign rd_en = (state_q == ST_SCAN) && (idx_q < count_q);

	always_ff @(posedge clk) begin
		if (acc_beat && cmd == sps_pkg::CMD_INSERT && count_q < CW'(TABLE_DEPTH))
			mem[count_q[AW-1:0]] <= val;
		if (rd_en)
			rd_data_s1 <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_beat) begin
						case (cmd)
							sps_pkg::CMD_CLEAR: count_q <= '0;
							sps_pkg::CMD_INSERT:
								if (count_q < CW'(TABLE_DEPTH))
									count_q <= count_q + 1'b1;
							sps_pkg::CMD_QUERY: begin
								idx_q <= '0;
								state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en)
						idx_q <= idx_q + 1'b1;
					else
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rd_valid_s1) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !rd_valid_s1)
			out_q <= acc;
	end

	sps_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.key      (val),
		.rd_valid (rd_valid_s1),
		.rd_data  (rd_data_s1),
		.acc      (acc)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {2'b00, out_q.above_value, out_q.below_value};
	assign m_tuser = {out_q.above_found, out_q.below_found};

	`include "strict_predecessor_successor_search_macros.svh"
	`SPS_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`SPS_ASSERT_IMP(a_read_in_range, rd_en, idx_q < count_q)
	`SPS_ASSERT_NXT(a_done_sets_out, state_q == ST_DONE && !rd_valid_s1, m_tvalid)
	`SPS_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !s_tready)
endmodule

[tb/sv/strict_predecessor_successor_search_tb.sv]
// Testbench for strict_predecessor_successor_search: drives clear/insert/query
// beats, predicts each query result from a local table copy, checks in order.
// Depends on sps_pkg and the block's RTL.
module strict_predecessor_successor_search_tb;
	localparam int unsigned DEPTH = 1024;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	sps_pkg::value_t  table_copy[DEPTH];
	int unsigned      entry_count;
	sps_pkg::result_t pending_results[$];
	int               error_count;
	int               send_idle_pct;
	int               recv_stall_pct;

	strict_predecessor_successor_search #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic sps_pkg::result_t search_neighbors(sps_pkg::value_t q);
		sps_pkg::result_t r;
		r = '0;
		for (int unsigned i = 0; i < entry_count; i++) begin
			if (table_copy[i] < q && (!r.below_found || table_copy[i] > r.below_value)) begin
				r.below_found = 1'b1;
				r.below_value = table_copy[i];
			end
			if (table_copy[i] > q && (!r.above_found || table_copy[i] < r.above_value)) begin
				r.above_found = 1'b1;
				r.above_value = table_copy[i];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic send_command(sps_pkg::cmd_t cmd, sps_pkg::value_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, v};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (cmd)
			sps_pkg::CMD_CLEAR: entry_count = 0;
			sps_pkg::CMD_INSERT: begin
				if (entry_count < DEPTH) begin
					table_copy[entry_count] = v;
					entry_count++;
				end
			end
			sps_pkg::CMD_QUERY: pending_results.push_back(search_neighbors(v));
			default: ;
		endcase
	endtask

	// receiver stalls and result checking
	always @(posedge clk) begin
		sps_pkg::result_t got;
		sps_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.below_found = m_tuser[0];
			got.below_value = m_tdata[30:0];
			got.above_found = m_tuser[1];
			got.above_value = m_tdata[61:31];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 32'(m_tdata[30:0]), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.below_found != want.below_found)
					report_mismatch("below_found", 32'(got.below_found),
						32'(want.below_found));
				if (got.below_value != want.below_value)
					report_mismatch("below_value", 32'(got.below_value),
						32'(want.below_value));
				if (got.above_found != want.above_found)
					report_mismatch("above_found", 32'(got.above_found),
						32'(want.above_found));
				if (got.above_value != want.above_value)
					report_mismatch("above_value", 32'(got.above_value),
						32'(want.above_value));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic drain_results();
		wait_results();
		repeat (DEPTH + 10) @(posedge clk);
	endtask

	function automatic sps_pkg::value_t random_value();
		case ($urandom_range(3))
			0: return sps_pkg::value_t'($urandom_range(15));
			1: return sps_pkg::value_t'(31'h7fff_fff0 + $urandom_range(15));
			default: return sps_pkg::value_t'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		sps_pkg::value_t maxv;
		maxv = '1;
		send_command(sps_pkg::CMD_QUERY, 31'd5);
		send_command(sps_pkg::CMD_INSERT, 31'd10);
		send_command(sps_pkg::CMD_INSERT, 31'd10);
		send_command(sps_pkg::CMD_INSERT, 31'd0);
		send_command(sps_pkg::CMD_INSERT, maxv);
		send_command(sps_pkg::CMD_QUERY, 31'd10);
		send_command(sps_pkg::CMD_QUERY, 31'd0);
		send_command(sps_pkg::CMD_QUERY, maxv);
		send_command(sps_pkg::CMD_QUERY, 31'd5);
		send_command(sps_pkg::CMD_NONE, 31'h2aaa_aaaa);
		send_command(sps_pkg::CMD_QUERY, 31'h5555_5555);
		send_command(sps_pkg::CMD_CLEAR, maxv);
		send_command(sps_pkg::CMD_QUERY, 31'd10);
		send_command(sps_pkg::CMD_INSERT, 31'd7);
		send_command(sps_pkg::CMD_QUERY, 31'd7);
		send_command(sps_pkg::CMD_QUERY, 31'd8);
		drain_results();
	endtask

	task automatic test_table_full();
		send_command(sps_pkg::CMD_CLEAR, '0);
		for (int i = 0; i < DEPTH; i++) send_command(sps_pkg::CMD_INSERT, 31'(i * 3 + 100));
		send_command(sps_pkg::CMD_INSERT, 31'd1);
		send_command(sps_pkg::CMD_INSERT, '1);
		send_command(sps_pkg::CMD_QUERY, 31'd50);
		send_command(sps_pkg::CMD_QUERY, 31'd500);
		send_command(sps_pkg::CMD_QUERY, '1);
		drain_results();
		send_command(sps_pkg::CMD_CLEAR, '0);
	endtask

	task automatic test_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 2) send_command(sps_pkg::CMD_CLEAR, random_value());
			else if (r < 4) send_command(sps_pkg::CMD_NONE, random_value());
			else if (r < 50 && entry_count < 48)
				send_command(sps_pkg::CMD_INSERT, random_value());
			else if (r < 55) send_command(sps_pkg::CMD_INSERT, random_value());
			else if (r < 70 && entry_count > 0)
				send_command(sps_pkg::CMD_QUERY, table_copy[$urandom_range(entry_count - 1)]);
			else send_command(sps_pkg::CMD_QUERY, random_value());
			if (i == n / 2) wait_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		entry_count = 0;
		error_count = 0;
		send_idle_pct = 18;
		recv_stall_pct = 46;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(260);
		test_table_full();
		send_idle_pct = 46;
		recv_stall_pct = 18;
		test_random(260);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(260);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
